### rtl/tcgw_pkg.sv
// Shared constants, character codes and state type for the text console glyph writer.
package tcgw_pkg;

    // Font geometry and tab spacing.
    localparam int GLYPH_COUNT = 256;
    localparam int GLYPH_ROWS  = 16;
    localparam int TAB_STOP    = 8;
    localparam int GLYPH_WIDTH = 8;

    // Derived sizes of the glyph store and its counters.
    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int GLYPH_W     = $clog2(GLYPH_COUNT);
    localparam int ROW_W       = $clog2(GLYPH_ROWS);
    localparam int ROW_CNT_W   = $clog2(GLYPH_ROWS + 1);

    // Fixed field widths of the channels.
    localparam int CHAR_W  = 8;
    localparam int FADDR_W = 12;
    localparam int BYTE_W  = 8;
    localparam int PX_W    = 11;
    localparam int PY_W    = 12;
    localparam int CUR_W   = 8;
    localparam int CFG_IDX_W = 1;

    // Character codes with a special meaning.
    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

    // Input modes.
    localparam logic MODE_PRINT = 1'b0;
    localparam logic MODE_LOAD  = 1'b1;

    // Result kinds.
    localparam logic KIND_GLYPH  = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS    = 1'd1;

    // Configuration reset values.
    localparam logic [CUR_W-1:0] TEXT_COLUMNS_RST = 8'd80;
    localparam logic [CUR_W-1:0] TEXT_ROWS_RST    = 8'd30;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROWS,
        ST_SCROLL
    } t_state;

endpackage

### rtl/tcgw_ifs.sv
// Handshake channel interfaces for characters, results and configuration writes.
interface tcgw_char_if
    import tcgw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [CHAR_W-1:0]  char_code;
    logic [FADDR_W-1:0] font_address;
    logic [BYTE_W-1:0]  font_byte;

    modport source (output valid, mode, char_code, font_address, font_byte, input ready);
    modport sink   (input valid, mode, char_code, font_address, font_byte, output ready);
endinterface

interface tcgw_result_if
    import tcgw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [PX_W-1:0]   pixel_x;
    logic [PY_W-1:0]   pixel_y;
    logic [BYTE_W-1:0] row_bits;
    logic              last;
    logic [CUR_W-1:0]  cursor_col;
    logic [CUR_W-1:0]  cursor_line;

    modport source (output valid, kind, pixel_x, pixel_y, row_bits, last, cursor_col,
                    cursor_line, input ready);
    modport sink   (input valid, kind, pixel_x, pixel_y, row_bits, last, cursor_col,
                    cursor_line, output ready);
endinterface

interface tcgw_cfg_if
    import tcgw_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CUR_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/tcgw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tcgw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/text_console_glyph_writer_core.sv
// Text console glyph writer: a font load word gives no result; a control code (CR, LF,
// tab, backspace) gives a scroll result only when the cursor passes the last text line; a
// printable character is accepted, the first row of its glyph is read from the glyph RAM,
// and then sixteen glyph rows follow, one per cycle while the output register is free, as
// fast as the single read port of the glyph RAM delivers them, plus a scroll result when
// the cursor passes the last text line. The next word is taken as soon as the last result
// sits in the output register. Configuration writes are taken at any time but must only
// be made while the block is idle. Glyph rows never loaded read back as undefined data.
module text_console_glyph_writer_core
    import tcgw_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcgw_char_if.sink     i_in,
    tcgw_result_if.source o_out,
    tcgw_cfg_if.sink      i_cfg
);

    // Controller and cursor state.
    t_state                r_state;
    t_state                n_state;
    logic [CUR_W-1:0]      r_text_columns;
    logic [CUR_W-1:0]      r_text_rows;
    logic [CUR_W-1:0]      r_cur_col;
    logic [CUR_W-1:0]      r_cur_line;

    // Work item held while its rows are read.
    logic [GLYPH_W-1:0]    r_glyph;
    logic [CUR_W-1:0]      r_old_col;
    logic [CUR_W-1:0]      r_old_line;
    logic                  r_scroll;
    logic [ROW_CNT_W-1:0]  r_issue_row;
    logic                  r_pend;
    logic [ROW_W-1:0]      r_pend_row;

    // Output register.
    logic                  r_o_valid;
    logic                  r_o_kind;
    logic [PX_W-1:0]       r_o_pixel_x;
    logic [PY_W-1:0]       r_o_pixel_y;
    logic [BYTE_W-1:0]     r_o_row_bits;
    logic                  r_o_last;
    logic [CUR_W-1:0]      r_o_cursor_col;
    logic [CUR_W-1:0]      r_o_cursor_line;

    // Combinational signals.
    logic                  in_ready;
    logic                  in_acc;
    logic                  out_free;
    logic                  rd_en;
    logic                  load_row;
    logic                  load_scroll;
    logic                  wr_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [BYTE_W-1:0]     rd_data;
    logic [BYTE_W-1:0]     flipped;
    logic [CUR_W:0]        col_calc;
    logic [CUR_W-1:0]      line_calc;
    logic                  dec_print;
    logic                  dec_scroll;
    logic [GLYPH_W-1:0]    dec_glyph;

    assign in_acc   = i_in.valid && in_ready;
    assign out_free = !r_o_valid || o_out.ready;
    assign i_in.ready  = in_ready;
    assign i_cfg.ready = i_rst_n;

    // Font byte bit reversal so that bit k is pixel column k.
    always_comb begin
        for (int i = 0; i < BYTE_W; i++) begin
            flipped[i] = i_in.font_byte[BYTE_W-1-i];
        end
    end

    assign wr_en = in_acc && (i_in.mode == MODE_LOAD) && (32'(i_in.font_address) < STORE_DEPTH);

    // Row address: glyph times rows plus row.
    assign rd_addr = ADDR_W'(32'(r_glyph) * GLYPH_ROWS + 32'(r_issue_row));

    tcgw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (ADDR_W'(i_in.font_address)),
        .i_wdata (flipped),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Cursor update for a character word.
    always_comb begin
        col_calc   = {1'b0, r_cur_col};
        line_calc  = r_cur_line;
        dec_print  = 1'b0;
        case (i_in.char_code)
            CH_CR: begin
                col_calc = '0;
            end
            CH_LF: begin
                col_calc  = '0;
                line_calc = (r_cur_line == '1) ? r_cur_line : r_cur_line + 1'b1;
            end
            CH_TAB: begin
                col_calc = (CUR_W+1)'((32'(r_cur_col) / TAB_STOP + 1) * TAB_STOP);
            end
            CH_BS: begin
                if (r_cur_col != '0) begin
                    col_calc = {1'b0, r_cur_col - 1'b1};
                end
            end
            default: begin
                dec_print = 1'b1;
                col_calc  = {1'b0, r_cur_col} + 1'b1;
            end
        endcase
        // Wrap to the next line at the column count.
        if (col_calc >= {1'b0, r_text_columns}) begin
            col_calc  = '0;
            line_calc = (line_calc == '1) ? line_calc : line_calc + 1'b1;
        end
        // Scroll when the line passes the row count.
        dec_scroll = (line_calc >= r_text_rows);
        if (dec_scroll && line_calc != '0) begin
            line_calc = line_calc - 1'b1;
        end
        // Codes beyond the glyph count fold back once.
        if (32'(i_in.char_code) >= GLYPH_COUNT) begin
            dec_glyph = GLYPH_W'(32'(i_in.char_code) - GLYPH_COUNT);
        end else begin
            dec_glyph = GLYPH_W'(i_in.char_code);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_in.mode == MODE_PRINT) begin
                    if (dec_print) begin
                        n_state = ST_ROWS;
                    end else if (dec_scroll) begin
                        n_state = ST_SCROLL;
                    end
                end
            end
            ST_ROWS: begin
                if (load_row && r_pend_row == ROW_W'(GLYPH_ROWS - 1)) begin
                    n_state = r_scroll ? ST_SCROLL : ST_IDLE;
                end
            end
            ST_SCROLL: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb begin
        in_ready    = 1'b0;
        rd_en       = 1'b0;
        load_row    = 1'b0;
        load_scroll = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_ready = i_rst_n;
            end
            ST_ROWS: begin
                load_row = r_pend && out_free;
                rd_en    = (r_issue_row < ROW_CNT_W'(GLYPH_ROWS)) && (!r_pend || load_row);
            end
            ST_SCROLL: begin
                load_scroll = out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // State, configuration and cursor registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_text_columns <= TEXT_COLUMNS_RST;
            r_text_rows    <= TEXT_ROWS_RST;
            r_cur_col      <= '0;
            r_cur_line     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_TEXT_COLUMNS: r_text_columns <= i_cfg.data;
                    REG_TEXT_ROWS:    r_text_rows    <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
            if (in_acc && i_in.mode == MODE_PRINT) begin
                r_cur_col  <= CUR_W'(col_calc);
                r_cur_line <= line_calc;
            end
        end
    end

    // Row sequencing over the glyph RAM.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_issue_row <= '0;
        end else if (in_acc) begin
            r_pend      <= 1'b0;
            r_issue_row <= '0;
        end else if (rd_en) begin
            r_pend      <= 1'b1;
            r_issue_row <= r_issue_row + 1'b1;
        end else if (load_row) begin
            r_pend <= 1'b0;
        end
    end

    // Item payload captured at acceptance and row tag of the pending read.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_glyph    <= dec_glyph;
            r_old_col  <= r_cur_col;
            r_old_line <= r_cur_line;
            r_scroll   <= dec_scroll;
        end
        if (rd_en) begin
            r_pend_row <= ROW_W'(r_issue_row);
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_row || load_scroll) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (load_row) begin
            r_o_kind        <= KIND_GLYPH;
            r_o_pixel_x     <= PX_W'(32'(r_old_col) * GLYPH_WIDTH);
            r_o_pixel_y     <= PY_W'(32'(r_old_line) * GLYPH_ROWS + 32'(r_pend_row));
            r_o_row_bits    <= rd_data;
            r_o_last        <= !r_scroll && (r_pend_row == ROW_W'(GLYPH_ROWS - 1));
            r_o_cursor_col  <= r_cur_col;
            r_o_cursor_line <= r_cur_line;
        end else if (load_scroll) begin
            r_o_kind        <= KIND_SCROLL;
            r_o_pixel_x     <= '0;
            r_o_pixel_y     <= '0;
            r_o_row_bits    <= '0;
            r_o_last        <= 1'b1;
            r_o_cursor_col  <= r_cur_col;
            r_o_cursor_line <= r_cur_line;
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.kind        = r_o_kind;
    assign o_out.pixel_x     = r_o_pixel_x;
    assign o_out.pixel_y     = r_o_pixel_y;
    assign o_out.row_bits    = r_o_row_bits;
    assign o_out.last        = r_o_last;
    assign o_out.cursor_col  = r_o_cursor_col;
    assign o_out.cursor_line = r_o_cursor_line;

    // A row read from the RAM stays pending until it moves into the output register.
    a_pend_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROWS && r_pend && !load_row) |=> r_pend)
        else $error("pending glyph row dropped");

    // The row issue counter never runs past the glyph height.
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue_row <= ROW_CNT_W'(GLYPH_ROWS))
        else $error("row issue counter out of range");

    // After a character the cursor column lies inside the line width, or at column zero.
    a_cursor_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.mode == MODE_PRINT) |=>
            (r_cur_col < $past(r_text_columns) || r_cur_col == '0))
        else $error("cursor column past the line width");

    // A character that does not scroll leaves the cursor line below the row count.
    a_cursor_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.mode == MODE_PRINT && !dec_scroll) |=>
            (r_cur_line < $past(r_text_rows)))
        else $error("cursor line past the screen height");

    // The scroll state is only reached for an item that scrolls.
    a_scroll_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCROLL) |-> r_scroll)
        else $error("scroll issued for an item without scroll");

endmodule
